FILE: hw/rtl/bdsc_pkg.sv
// ----------------------------------------------------------------------------
// bdsc_pkg
// Shared types, constants and calendar tables for the business day span
// counter: command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bdsc_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DOM_W   = 5;
	localparam int WDAY_W  = 3;
	localparam int DN_W    = 23;
	localparam int Q100_W  = 8;
	localparam int MUL_W   = 27;
	localparam int RAW_W   = 23;

	// floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
	localparam logic [12:0] RECIP_100   = 13'd5243;
	localparam int          RECIP_SHIFT = 19;

	// floor(x / 7) = (x * RECIP_7) >> RECIP_7_SHIFT for every 23-bit x
	localparam logic [23:0] RECIP_7       = 24'd9586981;
	localparam int          RECIP_7_SHIFT = 26;
	localparam int          PROD_W        = 47;

	localparam logic [WDAY_W-1:0] WD_FRI = 3'd5;
	localparam logic [WDAY_W-1:0] WD_SAT = 3'd6;
	localparam logic [3:0]        SEVEN  = 4'd7;

	typedef logic [DN_W-1:0]   dn_t;
	typedef logic [YEAR_W-1:0] year_t;

	typedef struct packed {
		logic load;
		logic sel;
		logic step0;
		logic step1;
		logic step2;
		logic step3;
		logic wd_start;
		logic wd_store;
		logic span_start;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic later;
		logic bad;
		logic out_free;
	} sts_t;

	function automatic logic [DOM_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DOM_W-1:0] len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// days before the first of the month, year starting in March
	function automatic logic [8:0] month_base(input logic [MONTH_W-1:0] m);
		logic [8:0] base;
		case (m)
			4'd3:    base = 9'd0;
			4'd4:    base = 9'd31;
			4'd5:    base = 9'd61;
			4'd6:    base = 9'd92;
			4'd7:    base = 9'd122;
			4'd8:    base = 9'd153;
			4'd9:    base = 9'd184;
			4'd10:   base = 9'd214;
			4'd11:   base = 9'd245;
			4'd12:   base = 9'd275;
			4'd1:    base = 9'd306;
			4'd2:    base = 9'd337;
			default: base = 9'd0;
		endcase
		return base;
	endfunction

	// business days among the first r days of a week starting on weekday sw
	function automatic logic [2:0] part_week(input logic [WDAY_W-1:0] sw,
		input logic [2:0] r);
		logic [2:0] cnt;
		logic [3:0] wd;
		cnt = 3'd0;
		for (int k = 0; k < 6; k++) begin
			wd = {1'b0, sw} + 4'(k);
			if (wd >= SEVEN)
				wd = wd - SEVEN;
			if ((3'(k) < r) && (wd[2:0] != WD_FRI) && (wd[2:0] != WD_SAT))
				cnt = cnt + 3'd1;
		end
		return cnt;
	endfunction

endpackage

FILE: hw/rtl/business_day_span_counter_unit.sv
// ----------------------------------------------------------------------------
// business_day_span_counter_unit
// Counts the days from a start date up to an end date, end excluded, whose
// weekday is neither Friday nor Saturday, and reports both weekdays.
// ----------------------------------------------------------------------------
// One transaction is in work at a time. Each date passes the four decode
// steps and the reciprocal divide by seven for its weekday, and the span is
// divided by seven once more unless either date is invalid or the end is not
// after the start. The next transaction is taken in the cycle after the last
// result is handed to the output register, while that result still waits for
// out_ready; a result that is not taken holds the next one in its last cycle.
// Invalid dates give bad_date with all other fields zero; counts saturate at
// 2**COUNT_BITS - 1.
module business_day_span_counter_unit #(
	parameter int COUNT_BITS = 22
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [13:0]            start_year,
	input  logic [3:0]             start_month,
	input  logic [4:0]             start_dom,
	input  logic [13:0]            end_year,
	input  logic [3:0]             end_month,
	input  logic [4:0]             end_dom,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COUNT_BITS-1:0]  business_days,
	output logic [2:0]             start_weekday,
	output logic [2:0]             end_weekday,
	output logic                   bad_date
);

	bdsc_pkg::cmd_t cmd;
	bdsc_pkg::sts_t sts;

	bdsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bdsc_datapath #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.start_year    (start_year),
		.start_month   (start_month),
		.start_dom     (start_dom),
		.end_year      (end_year),
		.end_month     (end_month),
		.end_dom       (end_dom),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.business_days (business_days),
		.start_weekday (start_weekday),
		.end_weekday   (end_weekday),
		.bad_date      (bad_date)
	);

endmodule

FILE: hw/rtl/bdsc_div7.sv
// ----------------------------------------------------------------------------
// bdsc_div7
// Divide by seven through a reciprocal multiply: the product is registered
// on start, quotient and remainder in the cycle after; done rises with them.
// ----------------------------------------------------------------------------
module bdsc_div7 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  bdsc_pkg::dn_t                 dividend,
	output logic                          done,
	output bdsc_pkg::dn_t                 quot,
	output logic [bdsc_pkg::WDAY_W-1:0]   rem
);

	logic                              step_q;
	logic                              done_q;
	bdsc_pkg::dn_t                     x_q;
	logic [bdsc_pkg::PROD_W-1:0]       prod_q;
	bdsc_pkg::dn_t                     quot_q;
	logic [bdsc_pkg::WDAY_W-1:0]       rem_q;
	bdsc_pkg::dn_t                     quot_d;
	bdsc_pkg::dn_t                     rem_d;

	assign quot_d = bdsc_pkg::dn_t'(prod_q[bdsc_pkg::PROD_W-1:bdsc_pkg::RECIP_7_SHIFT]);
	assign rem_d  = x_q - ((quot_d << 3) - quot_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			step_q <= start;
			done_q <= step_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= dividend;
			prod_q <= bdsc_pkg::PROD_W'(dividend) * bdsc_pkg::PROD_W'(bdsc_pkg::RECIP_7);
		end
		if (step_q) begin
			quot_q <= quot_d;
			rem_q  <= rem_d[bdsc_pkg::WDAY_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

FILE: hw/rtl/bdsc_datapath.sv
// ----------------------------------------------------------------------------
// bdsc_datapath
// Date decode, day-number build, weekday and span division, count assembly
// and the output register.
// ----------------------------------------------------------------------------
module bdsc_datapath #(
	parameter int COUNT_BITS = 22
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bdsc_pkg::cmd_t                cmd,
	output bdsc_pkg::sts_t                sts,
	input  logic [13:0]                   start_year,
	input  logic [3:0]                    start_month,
	input  logic [4:0]                    start_dom,
	input  logic [13:0]                   end_year,
	input  logic [3:0]                    end_month,
	input  logic [4:0]                    end_dom,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [COUNT_BITS-1:0]         business_days,
	output logic [2:0]                    start_weekday,
	output logic [2:0]                    end_weekday,
	output logic                          bad_date
);

	localparam int WIDE_W = (COUNT_BITS > bdsc_pkg::RAW_W) ? COUNT_BITS : bdsc_pkg::RAW_W;
	localparam logic [WIDE_W-1:0] CMAX = {WIDE_W{1'b1}} >> (WIDE_W - COUNT_BITS);

	bdsc_pkg::year_t               sy_q, ey_q, yy_q;
	logic [bdsc_pkg::MONTH_W-1:0]  sm_q, em_q;
	logic [bdsc_pkg::DOM_W-1:0]    sd_q, ed_q;
	logic                          a_q, leap_q, bad_q;
	logic [bdsc_pkg::MUL_W-1:0]    mul_q;
	logic [bdsc_pkg::Q100_W-1:0]   qyy_q;
	bdsc_pkg::dn_t                 part_q, ns_q, ne_q;
	logic [2:0]                    sw_q, ew_q;
	logic                          out_valid_q;
	logic [COUNT_BITS-1:0]         count_q;
	logic [2:0]                    sw_out_q, ew_out_q;
	logic                          bad_out_q;

	bdsc_pkg::year_t               y;
	logic [bdsc_pkg::MONTH_W-1:0]  m;
	logic [bdsc_pkg::DOM_W-1:0]    d;
	logic [bdsc_pkg::Q100_W-1:0]   q100;
	bdsc_pkg::year_t               hund;
	logic                          r0;
	logic                          valid;
	bdsc_pkg::dn_t                 yy_w, part_d, dn_d;
	logic                          div_start, div_done;
	bdsc_pkg::dn_t                 div_in, div_quot;
	logic [2:0]                    div_rem;
	logic                          later;
	logic [bdsc_pkg::RAW_W-1:0]    raw;
	logic [WIDE_W-1:0]             raw_w, sat;

	assign y = cmd.sel ? ey_q : sy_q;
	assign m = cmd.sel ? em_q : sm_q;
	assign d = cmd.sel ? ed_q : sd_q;

	assign q100 = mul_q[bdsc_pkg::MUL_W-1:bdsc_pkg::RECIP_SHIFT];
	assign hund = bdsc_pkg::year_t'({q100, 6'b0}) + bdsc_pkg::year_t'({q100, 5'b0})
		+ bdsc_pkg::year_t'({q100, 2'b0});
	assign r0   = (hund == y);

	assign valid = (y != '0) && (m >= 4'd1) && (m <= 4'd12) && (d != '0)
		&& (d <= bdsc_pkg::month_len(m, leap_q));

	assign yy_w   = bdsc_pkg::dn_t'(yy_q);
	assign part_d = (yy_w << 8) + (yy_w << 6) + (yy_w << 5) + (yy_w << 3)
		+ (yy_w << 2) + yy_w + (yy_w >> 2);
	assign dn_d   = part_q - bdsc_pkg::dn_t'(qyy_q) + bdsc_pkg::dn_t'(qyy_q >> 2)
		+ bdsc_pkg::dn_t'(d) + bdsc_pkg::dn_t'(bdsc_pkg::month_base(m))
		+ bdsc_pkg::dn_t'(2);

	assign later     = ne_q > ns_q;
	assign div_start = cmd.wd_start || cmd.span_start;
	assign div_in    = cmd.span_start ? (ne_q - ns_q) : (cmd.sel ? ne_q : ns_q);

	bdsc_div7 u_div7 (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_in),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign raw   = bdsc_pkg::RAW_W'({div_quot, 2'b0}) + bdsc_pkg::RAW_W'(div_quot)
		+ bdsc_pkg::RAW_W'(bdsc_pkg::part_week(sw_q, div_rem));
	assign raw_w = WIDE_W'(raw);
	assign sat   = (raw_w > CMAX) ? CMAX : raw_w;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sy_q <= start_year;
			sm_q <= start_month;
			sd_q <= start_dom;
			ey_q <= end_year;
			em_q <= end_month;
			ed_q <= end_dom;
		end
		if (cmd.step0) begin
			a_q   <= (m <= 4'd2);
			yy_q  <= y - bdsc_pkg::year_t'(m <= 4'd2);
			mul_q <= bdsc_pkg::MUL_W'(y) * bdsc_pkg::MUL_W'(bdsc_pkg::RECIP_100);
		end
		if (cmd.step1) begin
			qyy_q  <= (a_q && r0) ? q100 - 1'b1 : q100;
			leap_q <= (y[1:0] == 2'b00) && (!r0 || (q100[1:0] == 2'b00));
		end
		if (cmd.step2)
			part_q <= part_d;
		if (cmd.step3) begin
			if (cmd.sel)
				ne_q <= dn_d;
			else
				ns_q <= dn_d;
		end
		if (cmd.wd_store) begin
			if (cmd.sel)
				ew_q <= div_rem;
			else
				sw_q <= div_rem;
		end
		if (cmd.finish) begin
			bad_out_q <= bad_q;
			sw_out_q  <= bad_q ? 3'd0 : sw_q;
			ew_out_q  <= bad_q ? 3'd0 : ew_q;
			count_q   <= (bad_q || !later) ? '0 : sat[COUNT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bad_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				bad_q <= 1'b0;
			else if (cmd.step2 && !valid)
				bad_q <= 1'b1;
			if (cmd.finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign sts.div_done = div_done;
	assign sts.later    = later;
	assign sts.bad      = bad_q;
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign business_days = count_q;
	assign start_weekday = sw_out_q;
	assign end_weekday   = ew_out_q;
	assign bad_date      = bad_out_q;

endmodule

FILE: hw/rtl/bdsc_ctrl.sv
// ----------------------------------------------------------------------------
// bdsc_ctrl
// Sequencer: decodes both dates in turn, runs the weekday divides and, for a
// valid span, the span divide, then hands the result to the output register.
// ----------------------------------------------------------------------------
module bdsc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bdsc_pkg::sts_t  sts,
	output bdsc_pkg::cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_D0   = 4'd1;
	localparam logic [3:0] ST_D1   = 4'd2;
	localparam logic [3:0] ST_D2   = 4'd3;
	localparam logic [3:0] ST_D3   = 4'd4;
	localparam logic [3:0] ST_WDS  = 4'd5;
	localparam logic [3:0] ST_WDW  = 4'd6;
	localparam logic [3:0] ST_SPS  = 4'd7;
	localparam logic [3:0] ST_SPW  = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;

	logic [3:0] state_q, state_d;
	logic       sel_q, sel_d;

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd     = '0;
		cmd.sel = sel_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					sel_d    = 1'b0;
					state_d  = ST_D0;
				end
			end
			ST_D0: begin
				cmd.step0 = 1'b1;
				state_d   = ST_D1;
			end
			ST_D1: begin
				cmd.step1 = 1'b1;
				state_d   = ST_D2;
			end
			ST_D2: begin
				cmd.step2 = 1'b1;
				state_d   = ST_D3;
			end
			ST_D3: begin
				cmd.step3 = 1'b1;
				state_d   = ST_WDS;
			end
			ST_WDS: begin
				cmd.wd_start = 1'b1;
				state_d      = ST_WDW;
			end
			ST_WDW: begin
				if (sts.div_done) begin
					cmd.wd_store = 1'b1;
					if (sel_q) begin
						state_d = ST_SPS;
					end else begin
						sel_d   = 1'b1;
						state_d = ST_D0;
					end
				end
			end
			ST_SPS: begin
				if (sts.bad || !sts.later) begin
					state_d = ST_FIN;
				end else begin
					cmd.span_start = 1'b1;
					state_d        = ST_SPW;
				end
			end
			ST_SPW: begin
				if (sts.div_done)
					state_d = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

endmodule

FILE: hw/rtl/bdsc_checker.sv
// ----------------------------------------------------------------------------
// bdsc_checker
// Port-level checks for the business day span counter, bound to the top.
// ----------------------------------------------------------------------------
module bdsc_checker #(
	parameter int COUNT_BITS = 22
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic [13:0]            start_year,
	input logic [3:0]             start_month,
	input logic [4:0]             start_dom,
	input logic [13:0]            end_year,
	input logic [3:0]             end_month,
	input logic [4:0]             end_dom,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [COUNT_BITS-1:0]  business_days,
	input logic [2:0]             start_weekday,
	input logic [2:0]             end_weekday,
	input logic                   bad_date
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transaction");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(business_days) && $stable(start_weekday)
			&& $stable(end_weekday) && $stable(bad_date))
		else $error("stalled result changed");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_date |-> (business_days == '0) && (start_weekday == 3'd0)
			&& (end_weekday == 3'd0))
		else $error("bad date result carries nonzero fields");

	a_wday_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_date |-> (start_weekday != 3'd7) && (end_weekday != 3'd7))
		else $error("weekday out of range");

	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");

endmodule

bind business_day_span_counter_unit bdsc_checker #(.COUNT_BITS(COUNT_BITS)) u_bdsc_checker (.*);
